// ----- sv/memory_card_bus_responder_macros.svh -----
// Assertion helpers for the memory card bus responder.
// Both macros expect clk and rst_n in scope.
`ifndef MEMORY_CARD_BUS_RESPONDER_MACROS_SVH
`define MEMORY_CARD_BUS_RESPONDER_MACROS_SVH
`ifndef SYNTHESIS
`define MCBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MCBR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MCBR_ASSERT(lbl, prop, msg)
`define MCBR_NEVER(lbl, cond, msg)
`endif
`endif

// ----- sv/mcbr_pkg.sv -----
package mcbr_pkg;

  // transaction command held between slots
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_STATUS = 2'd3
  } cmd_t;

  // host bytes
  localparam logic [7:0] ACCESS_CODE = 8'h81;
  localparam logic [7:0] OP_READ     = 8'h52;
  localparam logic [7:0] OP_WRITE    = 8'h57;
  localparam logic [7:0] OP_STATUS   = 8'h53;

  // card bytes
  localparam logic [7:0] ID_HI       = 8'h5A;
  localparam logic [7:0] ID_LO       = 8'h5D;
  localparam logic [7:0] CMD_ACK_HI  = 8'h5C;
  localparam logic [7:0] CMD_ACK_LO  = 8'h5D;
  localparam logic [7:0] FILL_ZERO   = 8'h00;
  localparam logic [7:0] RELEASED    = 8'hFF;
  localparam logic [7:0] END_GOOD    = 8'h47;
  localparam logic [7:0] END_ERROR   = 8'h43;
  localparam logic [7:0] END_BAD     = 8'hFF;

  // status flag bits
  localparam logic [7:0] FLAG_POWER_ON  = 8'h08;
  localparam logic [7:0] FLAG_WRITE_ERR = 8'h04;
  localparam logic [7:0] FLAGS_RESET    = FLAG_POWER_ON;

  // fixed slot numbers within a transaction
  localparam logic [7:0] SLOT_ACCESS  = 8'd0;
  localparam logic [7:0] SLOT_CMD     = 8'd1;
  localparam logic [7:0] SLOT_ID_HI   = 8'd2;
  localparam logic [7:0] SLOT_ID_LO   = 8'd3;
  localparam logic [7:0] SLOT_ADDR_HI = 8'd4;
  localparam logic [7:0] SLOT_ADDR_LO = 8'd5;
  localparam logic [7:0] SLOT_RD_ACK_HI  = 8'd6;
  localparam logic [7:0] SLOT_RD_ACK_LO  = 8'd7;
  localparam logic [7:0] SLOT_RD_ECHO_HI = 8'd8;
  localparam logic [7:0] SLOT_RD_ECHO_LO = 8'd9;
  localparam logic [7:0] SLOT_RD_DATA = 8'd10;
  localparam logic [7:0] SLOT_WR_DATA = 8'd6;

  // identity sequence index of its final byte
  localparam logic [2:0] ID_SEQ_LAST = 3'd7;

  // commit sweep control, commit engine to datapath
  typedef struct packed {
    logic busy;
    logic buf_rd;
    logic store_wr;
  } sweep_ctl_t;

  // reply bytes of the status/identity command
  function automatic logic [7:0] id_reply(input logic [2:0] k);
    logic [7:0] r;
    case (k)
      3'd0:    r = 8'h5A;
      3'd1:    r = 8'h5D;
      3'd2:    r = 8'h5C;
      3'd3:    r = 8'h5D;
      3'd4:    r = 8'h04;
      3'd5:    r = 8'h00;
      3'd6:    r = 8'h00;
      default: r = 8'h80;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/mcbr_in_if.sv -----
interface mcbr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] host_byte;
  logic       first_byte;

  modport source (output valid, host_byte, first_byte, input ready);
  modport sink   (input valid, host_byte, first_byte, output ready);
endinterface

// ----- sv/mcbr_out_if.sv -----
interface mcbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       ack;

  modport source (output valid, reply_byte, ack, input ready);
  modport sink   (input valid, reply_byte, ack, output ready);
endinterface

// ----- sv/mcbr_ram.sv -----
// Simple dual-port RAM: one write port, one read port, registered read data.
module mcbr_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/mcbr_commit.sv -----
// Frame commit engine: walks the write buffer once, one byte per cycle,
// and writes each byte into the frame store in the cycle after its read.
module mcbr_commit #(
  parameter int FRAME_BYTES = 128,
  parameter int AW          = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output mcbr_pkg::sweep_ctl_t ctl,
  output logic [AW-1:0]       buf_idx,
  output logic [AW-1:0]       store_idx
);

  localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 1);

  logic          rd_act_r, rd_act_nxt;
  logic          wr_act_r, wr_act_nxt;
  logic [AW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [AW-1:0] wr_idx_r;

  // read phase walks every buffer index once; the write phase follows it, delayed by the wr_act_r register
  always_comb begin
    rd_act_nxt = rd_act_r;
    rd_cnt_nxt = rd_cnt_r;
    wr_act_nxt = rd_act_r;
    if (start) begin
      rd_act_nxt = 1'b1;
      rd_cnt_nxt = '0;
    end else if (rd_act_r) begin
      if (rd_cnt_r == LAST_IDX) begin
        rd_act_nxt = 1'b0;
      end
      rd_cnt_nxt = rd_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_act_r <= 1'b0;
      wr_act_r <= 1'b0;
      rd_cnt_r <= '0;
    end else begin
      rd_act_r <= rd_act_nxt;
      wr_act_r <= wr_act_nxt;
      rd_cnt_r <= rd_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_idx_r <= rd_cnt_r;
  end

  assign ctl.busy     = rd_act_r | wr_act_r;
  assign ctl.buf_rd   = rd_act_r;
  assign ctl.store_wr = wr_act_r;
  assign buf_idx      = rd_cnt_r;
  assign store_idx    = wr_idx_r;

endmodule

// ----- sv/memory_card_bus_responder.sv -----
// Memory card bus responder, card side of the byte-exchange protocol.
// in_ch carries one host byte per beat with first_byte set on the first
// byte after select; out_ch returns one beat per input beat: the card's
// reply byte and whether ACK follows. Both channels use valid/ready.
// Throughput: one beat per cycle while out_ch is ready and no commit runs;
// the pipeline is input register, a frame-store read issued on entry to
// the slot stage, then the slot stage that updates the transaction state
// and loads the output register, which presents each result.
// A successful frame write copies the write buffer into the frame store,
// one byte per cycle; beats wait meanwhile.
// Reset clears the transaction state (released, status 0x08); frame store
// and write buffer keep undefined contents and are not cleared.
// When out_ch stalls, the output register holds its beat and the slot
// stage and input register fill, then in_ch.ready drops.
`include "memory_card_bus_responder_macros.svh"
module memory_card_bus_responder #(
  parameter int FRAME_BYTES = 128,
  parameter int FRAME_COUNT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  mcbr_in_if.sink           in_ch,
  mcbr_out_if.source        out_ch
);

  localparam int FB_AW       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int STORE_DEPTH = FRAME_COUNT * FRAME_BYTES;
  localparam int FS_AW       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int FB_CW       = $clog2(FRAME_BYTES + 1);
  localparam int PROD_W      = 16 + FB_CW;
  localparam logic [7:0]  RD_DATA_END = 8'(10 + FRAME_BYTES);
  localparam logic [7:0]  WR_DATA_END = 8'(6 + FRAME_BYTES);
  localparam logic [7:0]  WR_ACK_HI   = 8'(7 + FRAME_BYTES);
  localparam logic [7:0]  WR_ACK_LO   = 8'(8 + FRAME_BYTES);
  localparam logic [16:0] FC_LIMIT    = 17'(FRAME_COUNT);

  // pipeline registers
  logic       s1_vld_r;
  logic [7:0] s1_host_r;
  logic       s1_first_r;
  logic       s2_vld_r;
  logic [7:0] s2_host_r;
  logic       s2_first_r;
  logic       out_vld_r;
  logic [7:0] out_reply_r;
  logic       out_ack_r;

  // transaction state
  logic [7:0]       pos_r, pos_nxt;
  mcbr_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [15:0]      faddr_r, faddr_nxt;
  logic [7:0]       csum_r, csum_nxt;
  logic [7:0]       flags_r, flags_nxt;
  logic             avalid_r, avalid_nxt;
  logic [FS_AW-1:0] base_r, base_nxt;

  // slot stage results
  logic       in_acc, s1_move, s2_fire;
  logic [7:0] reply;
  logic       ack, last, addr_step, wbuf_wr, commit_start;
  logic [15:0]       new_addr;
  logic [PROD_W-1:0] prod;
  logic [2:0]        id_k;

  // memories and commit engine
  mcbr_pkg::sweep_ctl_t sweep_ctl;
  logic [FB_AW-1:0] sweep_buf_idx, sweep_store_idx;
  logic [FB_AW-1:0] rd_off;
  logic             fs_rd_en;
  logic [FS_AW-1:0] fs_rd_addr, fs_wr_addr;
  logic [7:0]       fs_rd_data, wbuf_rd_data;

  // handshake
  assign s2_fire = s2_vld_r & (~out_vld_r | out_ch.ready) & ~sweep_ctl.busy;
  assign s1_move = s1_vld_r & (~s2_vld_r | s2_fire) & ~sweep_ctl.busy;
  assign in_ch.ready = ~s1_vld_r | s1_move;
  assign in_acc = in_ch.valid & in_ch.ready;

  assign new_addr = {faddr_r[15:8], s2_host_r};
  assign prod     = new_addr * FB_CW'(FRAME_BYTES);
  assign id_k     = 3'(pos_r - mcbr_pkg::SLOT_ID_HI);

  // slot stage: one host byte against the transaction state
  always_comb begin
    pos_nxt      = pos_r;
    cmd_nxt      = cmd_r;
    faddr_nxt    = faddr_r;
    csum_nxt     = csum_r;
    flags_nxt    = flags_r;
    avalid_nxt   = avalid_r;
    base_nxt     = base_r;
    reply        = mcbr_pkg::RELEASED;
    ack          = 1'b0;
    last         = 1'b0;
    addr_step    = 1'b0;
    wbuf_wr      = 1'b0;
    commit_start = 1'b0;
    if (s2_fire) begin
      if (s2_first_r) begin
        pos_nxt = mcbr_pkg::SLOT_ACCESS;
        cmd_nxt = mcbr_pkg::CMD_NONE;
        if (s2_host_r == mcbr_pkg::ACCESS_CODE) begin
          pos_nxt = mcbr_pkg::SLOT_CMD;
          ack     = 1'b1;
        end
      end else if (cmd_r == mcbr_pkg::CMD_NONE) begin
        if (pos_r == mcbr_pkg::SLOT_CMD) begin
          reply     = flags_r;
          flags_nxt = flags_r & ~mcbr_pkg::FLAG_WRITE_ERR;
          pos_nxt   = mcbr_pkg::SLOT_ID_HI;
          ack       = 1'b1;
          case (s2_host_r)
            mcbr_pkg::OP_READ:   cmd_nxt = mcbr_pkg::CMD_READ;
            mcbr_pkg::OP_WRITE:  cmd_nxt = mcbr_pkg::CMD_WRITE;
            mcbr_pkg::OP_STATUS: cmd_nxt = mcbr_pkg::CMD_STATUS;
            default: begin
              pos_nxt = mcbr_pkg::SLOT_ACCESS;
              ack     = 1'b0;
            end
          endcase
        end
      end else begin
        case (cmd_r)
          mcbr_pkg::CMD_READ: begin
            if (pos_r <= mcbr_pkg::SLOT_ADDR_LO) begin
              addr_step = 1'b1;
            end else if (pos_r == mcbr_pkg::SLOT_RD_ACK_HI) begin
              reply = mcbr_pkg::CMD_ACK_HI;
            end else if (pos_r == mcbr_pkg::SLOT_RD_ACK_LO) begin
              reply = mcbr_pkg::CMD_ACK_LO;
            end else if (pos_r == mcbr_pkg::SLOT_RD_ECHO_HI) begin
              reply = faddr_r[15:8];
            end else if (pos_r == mcbr_pkg::SLOT_RD_ECHO_LO) begin
              reply = faddr_r[7:0];
            end else if (pos_r < RD_DATA_END) begin
              if (avalid_r) begin
                reply    = fs_rd_data;
                csum_nxt = csum_r ^ fs_rd_data;
              end
            end else if (pos_r == RD_DATA_END) begin
              reply = avalid_r ? csum_r : mcbr_pkg::RELEASED;
            end else begin
              last  = 1'b1;
              reply = avalid_r ? mcbr_pkg::END_GOOD : mcbr_pkg::END_BAD;
            end
          end
          mcbr_pkg::CMD_WRITE: begin
            if (pos_r <= mcbr_pkg::SLOT_ADDR_LO) begin
              addr_step = 1'b1;
            end else if (pos_r < WR_DATA_END) begin
              wbuf_wr  = 1'b1;
              csum_nxt = csum_r ^ s2_host_r;
              reply    = mcbr_pkg::FILL_ZERO;
            end else if (pos_r == WR_DATA_END) begin
              reply = mcbr_pkg::FILL_ZERO;
              if (!avalid_r) begin
                flags_nxt = flags_r | mcbr_pkg::FLAG_WRITE_ERR;
                csum_nxt  = mcbr_pkg::END_BAD;
              end else if (s2_host_r != csum_r) begin
                flags_nxt = flags_r | mcbr_pkg::FLAG_WRITE_ERR;
                csum_nxt  = mcbr_pkg::END_ERROR;
              end else begin
                commit_start = 1'b1;
                flags_nxt = flags_r & ~(mcbr_pkg::FLAG_POWER_ON | mcbr_pkg::FLAG_WRITE_ERR);
                csum_nxt  = mcbr_pkg::END_GOOD;
              end
            end else if (pos_r == WR_ACK_HI) begin
              reply = mcbr_pkg::CMD_ACK_HI;
            end else if (pos_r == WR_ACK_LO) begin
              reply = mcbr_pkg::CMD_ACK_LO;
            end else begin
              last  = 1'b1;
              reply = csum_r;
            end
          end
          default: begin
            reply = mcbr_pkg::id_reply(id_k);
            last  = (id_k == mcbr_pkg::ID_SEQ_LAST);
          end
        endcase

        // identity and address slots shared by read and write
        if (addr_step) begin
          reply = mcbr_pkg::FILL_ZERO;
          if (pos_r == mcbr_pkg::SLOT_ID_HI) begin
            reply = mcbr_pkg::ID_HI;
          end else if (pos_r == mcbr_pkg::SLOT_ID_LO) begin
            reply = mcbr_pkg::ID_LO;
          end else if (pos_r == mcbr_pkg::SLOT_ADDR_HI) begin
            faddr_nxt = {s2_host_r, 8'h00};
            csum_nxt  = s2_host_r;
          end else begin
            faddr_nxt  = new_addr;
            csum_nxt   = csum_r ^ s2_host_r;
            avalid_nxt = ({1'b0, new_addr} < FC_LIMIT);
            base_nxt   = FS_AW'(prod);
          end
        end

        if (last) begin
          pos_nxt = mcbr_pkg::SLOT_ACCESS;
          cmd_nxt = mcbr_pkg::CMD_NONE;
        end else begin
          pos_nxt = pos_r + 8'd1;
          ack     = 1'b1;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pos_r     <= mcbr_pkg::SLOT_ACCESS;
      cmd_r     <= mcbr_pkg::CMD_NONE;
      faddr_r   <= '0;
      csum_r    <= '0;
      flags_r   <= mcbr_pkg::FLAGS_RESET;
      avalid_r  <= 1'b0;
    end else begin
      s1_vld_r  <= in_acc | (s1_vld_r & ~s1_move);
      s2_vld_r  <= s1_move | (s2_vld_r & ~s2_fire);
      out_vld_r <= s2_fire | (out_vld_r & ~out_ch.ready);
      pos_r     <= pos_nxt;
      cmd_r     <= cmd_nxt;
      faddr_r   <= faddr_nxt;
      csum_r    <= csum_nxt;
      flags_r   <= flags_nxt;
      avalid_r  <= avalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    if (in_acc) begin
      s1_host_r  <= in_ch.host_byte;
      s1_first_r <= in_ch.first_byte;
    end
    if (s1_move) begin
      s2_host_r  <= s1_host_r;
      s2_first_r <= s1_first_r;
    end
    if (s2_fire) begin
      out_reply_r <= reply;
      out_ack_r   <= ack;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.reply_byte = out_reply_r;
  assign out_ch.ack        = out_ack_r;

  // frame-store read issued as a beat enters the slot stage; position is
  // forwarded from the beat leaving it, base was settled slots earlier
  assign rd_off     = FB_AW'(pos_nxt - mcbr_pkg::SLOT_RD_DATA);
  assign fs_rd_addr = base_r + FS_AW'(rd_off);
  assign fs_rd_en   = s1_move & ~s1_first_r & (cmd_nxt == mcbr_pkg::CMD_READ) & avalid_nxt &
                      (pos_nxt >= mcbr_pkg::SLOT_RD_DATA) & (pos_nxt < RD_DATA_END);
  assign fs_wr_addr = base_r + FS_AW'(sweep_store_idx);

  mcbr_ram #(
    .DW    (8),
    .DEPTH (STORE_DEPTH),
    .AW    (FS_AW)
  ) u_frame_store (
    .clk     (clk),
    .wr_en   (sweep_ctl.store_wr),
    .wr_addr (fs_wr_addr),
    .wr_data (wbuf_rd_data),
    .rd_en   (fs_rd_en),
    .rd_addr (fs_rd_addr),
    .rd_data (fs_rd_data)
  );

  mcbr_ram #(
    .DW    (8),
    .DEPTH (FRAME_BYTES),
    .AW    (FB_AW)
  ) u_write_buffer (
    .clk     (clk),
    .wr_en   (wbuf_wr),
    .wr_addr (FB_AW'(pos_r - mcbr_pkg::SLOT_WR_DATA)),
    .wr_data (s2_host_r),
    .rd_en   (sweep_ctl.buf_rd),
    .rd_addr (sweep_buf_idx),
    .rd_data (wbuf_rd_data)
  );

  mcbr_commit #(
    .FRAME_BYTES (FRAME_BYTES),
    .AW          (FB_AW)
  ) u_commit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (commit_start),
    .ctl       (sweep_ctl),
    .buf_idx   (sweep_buf_idx),
    .store_idx (sweep_store_idx)
  );

  // frame-store reads never overlap a commit
  `MCBR_NEVER(a_no_read_in_commit, fs_rd_en && sweep_ctl.store_wr, "store read during commit")
  // a commit only follows a write to a valid frame
  `MCBR_ASSERT(a_commit_valid, $rose(sweep_ctl.busy) |-> $past(cmd_r == mcbr_pkg::CMD_WRITE && avalid_r), "commit without valid write")
  // a beat without ACK leaves the card released
  `MCBR_ASSERT(a_nack_releases, s2_fire && !ack |=> pos_r == mcbr_pkg::SLOT_ACCESS && cmd_r == mcbr_pkg::CMD_NONE, "card not released after no-ack beat")

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import mcbr_pkg::*;

  localparam int FRAME_BYTES  = 128;
  localparam int FRAME_COUNT  = 1024;
  localparam int RANDOM_BYTES = 250;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_MAX   = 10;

  // last slot of each transaction kind, and the write checksum slot
  localparam int READ_LAST   = SLOT_RD_DATA + FRAME_BYTES + 1;
  localparam int WRITE_SUM   = SLOT_WR_DATA + FRAME_BYTES;
  localparam int WRITE_LAST  = WRITE_SUM + 3;
  localparam int STATUS_LAST = SLOT_ID_HI + 7;

  // identity bytes sent by the status command, slot 2 first
  localparam logic [7:0][7:0] IDENT_SEQ = {8'h80, 8'h00, 8'h00, 8'h04,
                                           CMD_ACK_LO, CMD_ACK_HI, ID_LO, ID_HI};

  typedef enum int {PAT_RANDOM, PAT_ZEROS, PAT_ONES} data_pat_t;

  typedef struct packed {
    logic [7:0] reply;
    logic       ack;
  } card_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  mcbr_in_if  in_ch ();
  mcbr_out_if out_ch ();

  memory_card_bus_responder #(
    .FRAME_BYTES(FRAME_BYTES),
    .FRAME_COUNT(FRAME_COUNT)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // card state as the host should see it
  logic [7:0]  card_mem [FRAME_COUNT * FRAME_BYTES];
  logic [7:0]  wbuf [FRAME_BYTES];
  bit          frame_written [FRAME_COUNT];
  int          written_frames [$];
  int          slot;
  cmd_t        cmd;
  logic [15:0] addr;
  logic [7:0]  xsum;
  logic [7:0]  flags;
  bit          addr_ok;

  card_reply_t pending_replies [$];
  int          fail_count = 0;
  int          bytes_sent = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int unsigned cycle_count = 0;

  function automatic void card_reset();
    slot    = SLOT_ACCESS;
    cmd     = CMD_NONE;
    addr    = '0;
    xsum    = '0;
    flags   = FLAGS_RESET;
    addr_ok = 1'b0;
  endfunction

  // one byte slot: update the card state, return the reply and ACK
  function automatic void card_reply(input logic [7:0] hb, input logic fb,
                                     output logic [7:0] rb, output logic ak);
    int         p;
    bit         last;
    logic [2:0] k;
    logic [7:0] d;
    p    = slot;
    last = 1'b0;
    rb   = RELEASED;
    ak   = 1'b0;
    if (fb) begin
      slot = SLOT_ACCESS;
      cmd  = CMD_NONE;
      if (hb == ACCESS_CODE) begin
        slot = SLOT_CMD;
        ak   = 1'b1;
      end
    end else if (cmd == CMD_NONE) begin
      // command slot; any other slot here means released
      if (slot == SLOT_CMD) begin
        rb    = flags;
        flags &= ~FLAG_WRITE_ERR;
        case (hb)
          OP_READ:   cmd = CMD_READ;
          OP_WRITE:  cmd = CMD_WRITE;
          OP_STATUS: cmd = CMD_STATUS;
          default:   cmd = CMD_NONE;
        endcase
        if (cmd != CMD_NONE) begin
          slot = SLOT_ID_HI;
          ak   = 1'b1;
        end else begin
          slot = SLOT_ACCESS;
        end
      end
    end else begin
      if (cmd == CMD_STATUS) begin
        k    = 3'(p - SLOT_ID_HI);
        rb   = IDENT_SEQ[k];
        last = (k == ID_SEQ_LAST);
      end else if (p == SLOT_ID_HI) begin
        rb = ID_HI;
      end else if (p == SLOT_ID_LO) begin
        rb = ID_LO;
      end else if (p == SLOT_ADDR_HI) begin
        addr = {hb, 8'h00};
        xsum = hb;
        rb   = FILL_ZERO;
      end else if (p == SLOT_ADDR_LO) begin
        addr[7:0] = hb;
        xsum      ^= hb;
        addr_ok   = (addr < FRAME_COUNT);
        rb        = FILL_ZERO;
      end else if (cmd == CMD_READ) begin
        if (p == SLOT_RD_ACK_HI) rb = CMD_ACK_HI;
        else if (p == SLOT_RD_ACK_LO) rb = CMD_ACK_LO;
        else if (p == SLOT_RD_ECHO_HI) rb = addr[15:8];
        else if (p == SLOT_RD_ECHO_LO) rb = addr[7:0];
        else if (p < SLOT_RD_DATA + FRAME_BYTES) begin
          rb = END_BAD;
          if (addr_ok) begin
            d    = card_mem[int'(addr) * FRAME_BYTES + p - SLOT_RD_DATA];
            xsum ^= d;
            rb   = d;
          end
        end else if (p == SLOT_RD_DATA + FRAME_BYTES) begin
          rb = addr_ok ? xsum : END_BAD;
        end else begin
          last = 1'b1;
          rb   = addr_ok ? END_GOOD : END_BAD;
        end
      end else begin
        // write: data in, checksum in, then the end code prepared here
        rb = FILL_ZERO;
        if (p < WRITE_SUM) begin
          wbuf[p - SLOT_WR_DATA] = hb;
          xsum ^= hb;
        end else if (p == WRITE_SUM) begin
          if (!addr_ok) begin
            flags |= FLAG_WRITE_ERR;
            xsum  = END_BAD;
          end else if (hb != xsum) begin
            flags |= FLAG_WRITE_ERR;
            xsum  = END_ERROR;
          end else begin
            for (int i = 0; i < FRAME_BYTES; i++)
              card_mem[int'(addr) * FRAME_BYTES + i] = wbuf[i];
            if (!frame_written[addr]) begin
              frame_written[addr] = 1'b1;
              written_frames.push_back(int'(addr));
            end
            flags &= ~(FLAG_POWER_ON | FLAG_WRITE_ERR);
            xsum  = END_GOOD;
          end
        end else if (p == WRITE_SUM + 1) begin
          rb = CMD_ACK_HI;
        end else if (p == WRITE_SUM + 2) begin
          rb = CMD_ACK_LO;
        end else begin
          last = 1'b1;
          rb   = xsum;
        end
      end
      if (last) begin
        slot = SLOT_ACCESS;
        cmd  = CMD_NONE;
      end else begin
        slot = (p + 1) & 8'hFF;
        ak   = 1'b1;
      end
    end
  endfunction

  // a data slot of a read from a frame nobody has written yet
  function automatic bit reads_unwritten(input logic fb);
    return !fb && cmd == CMD_READ && slot >= SLOT_RD_DATA &&
           slot < SLOT_RD_DATA + FRAME_BYTES && addr_ok && !frame_written[addr];
  endfunction

  function automatic logic [15:0] pick_read_addr();
    if (written_frames.size() == 0 || $urandom_range(0, 5) == 0)
      return 16'($urandom_range(FRAME_COUNT, 16'hFFFF));
    return 16'(written_frames[$urandom_range(0, written_frames.size() - 1)]);
  endfunction

  function automatic logic [15:0] pick_write_addr();
    case ($urandom_range(0, 7))
      0:       return 16'($urandom_range(FRAME_COUNT, 16'hFFFF));
      1:       return 16'($urandom_range(0, 3));
      2:       return 16'($urandom_range(FRAME_COUNT - 4, FRAME_COUNT - 1));
      default: return 16'($urandom_range(0, FRAME_COUNT - 1));
    endcase
  endfunction

  function automatic data_pat_t pick_pattern();
    case ($urandom_range(0, 9))
      0:       return PAT_ZEROS;
      1:       return PAT_ONES;
      default: return PAT_RANDOM;
    endcase
  endfunction

  function automatic logic [7:0] odd_command();
    logic [7:0] b;
    do b = 8'($urandom()); while (b == OP_READ || b == OP_WRITE || b == OP_STATUS);
    return b;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 15;
      default: return 40;
    endcase
  endfunction

  // send one host beat; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] hb, input logic fb);
    logic [7:0] rb;
    logic       ak;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    if (reads_unwritten(fb)) fb = 1'b1;
    in_ch.valid      = 1'b1;
    in_ch.host_byte  = hb;
    in_ch.first_byte = fb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // bytes to a released card do not count as traffic
    if (fb || slot != SLOT_ACCESS) bytes_sent++;
    card_reply(hb, fb, rb, ak);
    pending_replies.push_back('{reply: rb, ack: ak});
    @(negedge clk);
  endtask

  // one transaction from select; cut > 0 stops after that many slots
  task automatic card_txn(input logic [7:0] op, input logic [15:0] a, input bit bad_sum,
                          input int cut, input data_pat_t pat);
    int         last_slot;
    logic [7:0] hb;
    logic [7:0] chk;
    chk = a[15:8] ^ a[7:0];
    case (op)
      OP_READ:   last_slot = READ_LAST;
      OP_WRITE:  last_slot = WRITE_LAST;
      OP_STATUS: last_slot = STATUS_LAST;
      default:   last_slot = SLOT_CMD;
    endcase
    if (cut == 0 || cut > last_slot + 1) cut = last_slot + 1;
    send_byte(ACCESS_CODE, 1'b1);
    for (int p = SLOT_CMD; p < cut; p++) begin
      hb = 8'($urandom());
      if (p == SLOT_CMD) begin
        hb = op;
      end else if (op != OP_STATUS && p == SLOT_ADDR_HI) begin
        hb = a[15:8];
      end else if (op != OP_STATUS && p == SLOT_ADDR_LO) begin
        hb = a[7:0];
      end else if (op == OP_WRITE && p >= SLOT_WR_DATA && p < WRITE_SUM) begin
        if (pat == PAT_ZEROS) hb = 8'h00;
        else if (pat == PAT_ONES) hb = 8'hFF;
        chk ^= hb;
      end else if (op == OP_WRITE && p == WRITE_SUM) begin
        hb = bad_sum ? chk ^ (8'h01 << $urandom_range(0, 7)) : chk;
      end
      send_byte(hb, 1'b0);
    end
  endtask

  // random beats, some of them looking like the start of a transaction
  task automatic line_noise(input int n);
    logic [7:0] hb;
    repeat (n) begin
      case ($urandom_range(0, 5))
        0:       hb = ACCESS_CODE;
        1:       hb = OP_READ;
        2:       hb = OP_WRITE;
        3:       hb = OP_STATUS;
        default: hb = 8'($urandom());
      endcase
      send_byte(hb, $urandom_range(0, 3) == 0);
    end
  endtask

  // result check, sampled at the rising edge
  always @(posedge clk) begin
    card_reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected beat: reply %h ack %b", out_ch.reply_byte, out_ch.ack);
      end else begin
        want = pending_replies.pop_front();
        if (out_ch.reply_byte !== want.reply || out_ch.ack !== want.ack) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("mismatch: reply %h ack %b, expected reply %h ack %b",
                     out_ch.reply_byte, out_ch.ack, want.reply, want.ack);
        end
      end
    end
  end

  // receiver stalls in random bursts
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_ch.ready = 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // status right after reset shows the power-on flag
  task automatic test_power_on_status();
    card_txn(OP_STATUS, '0, 1'b0, 0, PAT_RANDOM);
  endtask

  // bad access, released card, unknown command, reselect at command slot
  task automatic test_select_errors();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(ACCESS_CODE, 1'b0);
    card_txn(odd_command(), '0, 1'b0, 0, PAT_RANDOM);
    send_byte(OP_READ, 1'b0);
    send_byte(ACCESS_CODE, 1'b1);
    send_byte(ACCESS_CODE, 1'b1);
    send_byte(OP_STATUS, 1'b1);
    card_txn(8'hFF, '0, 1'b0, 0, PAT_RANDOM);
  endtask

  // first and last frame, all-zero and all-one data
  task automatic test_frame_extremes();
    card_txn(OP_WRITE, 16'd0, 1'b0, 0, PAT_ZEROS);
    card_txn(OP_WRITE, 16'(FRAME_COUNT - 1), 1'b0, 0, PAT_ONES);
    card_txn(OP_READ, 16'(FRAME_COUNT - 1), 1'b0, 0, PAT_RANDOM);
  endtask

  // checksum error, bad addresses on write and read
  task automatic test_write_errors();
    card_txn(OP_WRITE, 16'(FRAME_COUNT - 1), 1'b1, 0, PAT_RANDOM);
    card_txn(OP_STATUS, '0, 1'b0, 0, PAT_RANDOM);
    card_txn(OP_WRITE, 16'(FRAME_COUNT), 1'b0, 0, PAT_RANDOM);
    card_txn(OP_READ, 16'hFFFF, 1'b0, 0, PAT_RANDOM);
  endtask

  // select in the middle of writes and reads; nothing partial may commit
  task automatic test_reselect();
    card_txn(OP_WRITE, 16'd0, 1'b0, WRITE_SUM, PAT_ONES);
    card_txn(OP_READ, 16'd0, 1'b0, SLOT_RD_DATA + 3, PAT_RANDOM);
    card_txn(OP_WRITE, 16'd5, 1'b0, WRITE_SUM + 1, PAT_RANDOM);
    card_txn(OP_READ, 16'd5, 1'b0, 0, PAT_RANDOM);
    card_txn(OP_STATUS, '0, 1'b0, 4, PAT_RANDOM);
  endtask

  task automatic test_random_traffic();
    int         stop_at;
    int         pick;
    logic [7:0] op;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      idle_pct  = pick_pct();
      stall_pct = pick_pct();
      pick      = $urandom_range(0, 99);
      if (pick < 30) begin
        card_txn(OP_WRITE, pick_write_addr(), $urandom_range(0, 4) == 0, 0, pick_pattern());
      end else if (pick < 55) begin
        card_txn(OP_READ, pick_read_addr(), 1'b0, 0, PAT_RANDOM);
      end else if (pick < 65) begin
        card_txn(OP_STATUS, '0, 1'b0, 0, PAT_RANDOM);
      end else if (pick < 80) begin
        case ($urandom_range(0, 2))
          0:       op = OP_READ;
          1:       op = OP_WRITE;
          default: op = OP_STATUS;
        endcase
        card_txn(op, (op == OP_READ) ? pick_read_addr() : pick_write_addr(), 1'b0,
                 $urandom_range(2, READ_LAST), pick_pattern());
      end else if (pick < 88) begin
        card_txn(odd_command(), '0, 1'b0, 0, PAT_RANDOM);
      end else begin
        line_noise($urandom_range(1, 12));
      end
    end
  endtask

  // closing stretch at full rate, no idling on either side
  task automatic test_back_to_back();
    idle_pct  = 0;
    stall_pct = 0;
    card_txn(OP_WRITE, 16'd2, 1'b0, 0, PAT_RANDOM);
    card_txn(OP_READ, 16'd2, 1'b0, 0, PAT_RANDOM);
    card_txn(OP_STATUS, '0, 1'b0, 0, PAT_RANDOM);
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.host_byte  = 8'h00;
    in_ch.first_byte = 1'b0;
    rst_n            = 1'b0;
    card_reset();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    idle_pct  = 10;
    stall_pct = 10;
    test_power_on_status();
    test_select_errors();
    test_frame_extremes();
    test_write_errors();
    test_reselect();
    test_random_traffic();
    test_back_to_back();

    in_ch.valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    // let a trailing frame commit finish; any extra beat is a failure
    repeat (FRAME_BYTES + 16) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
